// ===== hdl/lscl_pkg.sv =====
// ----------------------------------------------------------------------------
// lscl_pkg
// Shared types and constants for the five-sensor line locator.
// ----------------------------------------------------------------------------
package lscl_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int CENTRE_INDEX = 2;
    localparam int KIND_W       = 3;
    localparam int POS_W        = 13;
    localparam int IDX_W        = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_START      = 3'd0,
        KIND_CALIB      = 3'd1,
        KIND_FINISH     = 3'd2,
        KIND_LOAD_LOW   = 3'd3,
        KIND_LOAD_HIGH  = 3'd4,
        KIND_MEASURE    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_MERGE
    } t_state;

    typedef struct packed {
        logic  upd;
        t_kind kind;
        logic  swap;
        logic  mul;
        logic  step;
    } t_lane_ctrl;

endpackage

// ===== hdl/lscl_lane.sv =====
// ----------------------------------------------------------------------------
// lscl_lane
// One sensor lane: holds the calibration bounds and normalizes a sample by a
// scaled multiply followed by a bit-serial restoring divide.
// ----------------------------------------------------------------------------
module lscl_lane
    import lscl_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FULL_SCALE  = 1000,
    localparam int NORM_W     = $clog2(FULL_SCALE + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lane_ctrl             i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [NORM_W-1:0]      o_norm
);

    localparam int SB = SAMPLE_BITS;
    localparam int NW = SB + NORM_W;

    logic [SB-1:0]        r_lo;
    logic [SB-1:0]        r_hi;
    logic [SB-1:0]        r_x;
    logic [NW-1:0]        r_num;
    logic [SB-1:0]        r_rem;
    logic [SB-1:0]        r_den;
    logic                 r_zero;

    logic signed [SB:0]   w_diff;
    logic signed [SB:0]   w_span;
    logic [SB-1:0]        w_adiff;
    logic [SB-1:0]        w_aspan;
    logic [NW-1:0]        w_prod;
    logic [SB:0]          w_rem_sh;
    logic [SB:0]          w_rem_sub;
    logic                 w_ge;

    assign w_diff    = $signed({1'b0, r_x}) - $signed({1'b0, r_lo});
    assign w_span    = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});
    assign w_adiff   = w_diff[SB] ? SB'(-w_diff) : w_diff[SB-1:0];
    assign w_aspan   = w_span[SB] ? SB'(-w_span) : w_span[SB-1:0];
    assign w_prod    = NW'(w_adiff) * NW'(FULL_SCALE);
    assign w_rem_sh  = {r_rem, r_num[NW-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '1;
        end else if (i_ctrl.upd) begin
            case (i_ctrl.kind)
                KIND_START: begin
                    r_lo <= i_sample;
                    r_hi <= i_sample;
                end
                KIND_CALIB: begin
                    if (i_sample < r_lo) r_lo <= i_sample;
                    if (i_sample > r_hi) r_hi <= i_sample;
                end
                KIND_FINISH: begin
                    if (i_ctrl.swap) begin
                        r_lo <= r_hi;
                        r_hi <= r_lo;
                    end
                end
                KIND_LOAD_LOW:  r_lo <= i_sample;
                KIND_LOAD_HIGH: r_hi <= i_sample;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.upd && i_ctrl.kind == KIND_MEASURE) begin
            r_x <= i_sample;
        end
        if (i_ctrl.mul) begin
            r_num  <= w_prod;
            r_den  <= w_aspan;
            r_rem  <= '0;
            r_zero <= (w_span == '0) || (w_diff == '0) || (w_diff[SB] != w_span[SB]);
        end else if (i_ctrl.step) begin
            r_rem <= w_ge ? w_rem_sub[SB-1:0] : w_rem_sh[SB-1:0];
            r_num <= {r_num[NW-2:0], w_ge};
        end
    end

    assign o_norm = r_zero ? '0 :
                    (r_num > NW'(FULL_SCALE)) ? NORM_W'(FULL_SCALE) : r_num[NORM_W-1:0];

endmodule

// ===== hdl/lscl_merge.sv =====
// ----------------------------------------------------------------------------
// lscl_merge
// Combine the lane results: pick the strongest sensor, sign the offset from
// its neighbours and register the saturated line position.
// ----------------------------------------------------------------------------
module lscl_merge
    import lscl_pkg::*;
#(
    parameter int FULL_SCALE = 1000,
    localparam int NORM_W    = $clog2(FULL_SCALE + 1)
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [NORM_W-1:0] i_norm [SENSOR_COUNT],
    output logic [POS_W-1:0]  o_position,
    output logic [IDX_W-1:0]  o_strongest
);

    localparam int CW = (NORM_W + 3 > POS_W + 1) ? NORM_W + 3 : POS_W + 1;
    localparam logic signed [CW-1:0] FS_S   = CW'(FULL_SCALE);
    localparam logic signed [CW-1:0] POS_LO = CW'(-(2 ** (POS_W - 1)));
    localparam logic signed [CW-1:0] POS_HI = CW'((2 ** (POS_W - 1)) - 1);

    logic [IDX_W-1:0] w_best;
    logic [POS_W-1:0] w_pos;
    logic [POS_W-1:0] r_pos;
    logic [IDX_W-1:0] r_idx;

    always_comb begin
        logic [NORM_W-1:0]      peak;
        logic                   neg;
        logic signed [CW-1:0]   base;
        logic signed [CW-1:0]   pk;
        logic signed [CW-1:0]   sum;
        w_best = IDX_W'(CENTRE_INDEX);
        peak   = i_norm[CENTRE_INDEX];
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (i_norm[i] > peak) begin
                peak   = i_norm[i];
                w_best = IDX_W'(i);
            end
        end
        case (w_best)
            IDX_W'(0):                neg = 1'b1;
            IDX_W'(SENSOR_COUNT - 1): neg = 1'b0;
            default:                  neg = i_norm[w_best - 1'b1] > i_norm[w_best + 1'b1];
        endcase
        case (w_best)
            IDX_W'(0): base = -(FS_S + FS_S);
            IDX_W'(1): base = -FS_S;
            IDX_W'(3): base = FS_S;
            IDX_W'(4): base = FS_S + FS_S;
            default:   base = '0;
        endcase
        pk  = $signed(CW'(peak));
        sum = neg ? base - pk : base + pk;
        if (sum < POS_LO) begin
            sum = POS_LO;
        end else if (sum > POS_HI) begin
            sum = POS_HI;
        end
        w_pos = sum[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pos <= w_pos;
            r_idx <= w_best;
        end
    end

    assign o_position  = r_pos;
    assign o_strongest = r_idx;

endmodule

// ===== hdl/line_sensor_calibrate_and_locate.sv =====
// ----------------------------------------------------------------------------
// line_sensor_calibrate_and_locate
// Five-sensor floor line locator with per-sensor min/max calibration.
//
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   sample far left, left, centre, right,       kind
//               far right (SAMPLE_BITS each), zero pad
// m_axis   out  line_position (13, signed),                 -
//               strongest_sensor (3)
//
// Calibration and load beats update the bounds as they are accepted.
// A measure beat runs through the multiply, the bit-serial divide in each of
// the five lanes and the merge before the next beat is taken.
// One item is in work at a time; a finished result waits in the output
// register while the next beat is taken.
// Reset is synchronous; bounds return to low zero and high all ones.
// ----------------------------------------------------------------------------
module line_sensor_calibrate_and_locate
    import lscl_pkg::*;
#(
    parameter int FULL_SCALE  = 1000,
    parameter int SAMPLE_BITS = 12,
    localparam int IN_W       = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((POS_W + IDX_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // far left, left, centre, right, far right
    input  logic [KIND_W-1:0] s_axis_tuser,   // kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // line_position, strongest_sensor
);

    localparam int NORM_W = $clog2(FULL_SCALE + 1);
    localparam int NW     = SAMPLE_BITS + NORM_W;
    localparam int CNT_W  = $clog2(NW + 1);
    localparam int SUM_W  = (SAMPLE_BITS + 3 > 14) ? SAMPLE_BITS + 3 : 14;
    localparam logic [SUM_W-1:0] SWAP_LEVEL = SUM_W'(SENSOR_COUNT * (FULL_SCALE / 2));

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_out_valid;
    logic              n_out_valid;

    t_kind             w_kind;
    logic              w_accept;
    logic              w_slot_free;
    logic              w_merge_load;
    logic [SUM_W-1:0]  w_sum;
    t_lane_ctrl        w_ctrl;
    logic [NORM_W-1:0] w_norm [SENSOR_COUNT];
    logic [POS_W-1:0]  w_position;
    logic [IDX_W-1:0]  w_strongest;

    assign w_kind      = t_kind'(s_axis_tuser);
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_out_valid || m_axis_tready;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            w_sum = w_sum + SUM_W'(s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_kind == KIND_MEASURE) n_state = ST_MUL;
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(NW - 1)) n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (w_slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_merge_load  = 1'b0;
        w_ctrl.upd    = 1'b0;
        w_ctrl.kind   = w_kind;
        w_ctrl.swap   = w_sum > SWAP_LEVEL;
        w_ctrl.mul    = 1'b0;
        w_ctrl.step   = 1'b0;
        n_cnt         = '0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_ctrl.upd    = s_axis_tvalid;
            end
            ST_MUL:   w_ctrl.mul = 1'b1;
            ST_DIV: begin
                w_ctrl.step = 1'b1;
                if (r_cnt != CNT_W'(NW - 1)) n_cnt = r_cnt + 1'b1;
            end
            ST_MERGE: w_merge_load = w_slot_free;
            default: ;
        endcase
    end

    always_comb begin
        if (w_merge_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lscl_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .FULL_SCALE  (FULL_SCALE)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_sample (s_axis_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_norm   (w_norm[g])
        );
    end

    lscl_merge #(
        .FULL_SCALE (FULL_SCALE)
    ) u_merge (
        .i_clk       (i_clk),
        .i_load      (w_merge_load),
        .i_norm      (w_norm),
        .o_position  (w_position),
        .o_strongest (w_strongest)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({w_strongest, w_position});

`ifndef NO_ASSERTIONS
    a_measure_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind == KIND_MEASURE) |=> (r_state == ST_MUL))
        else $error("measure beat did not start the multiply");

    a_no_result_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind != KIND_MEASURE && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result raised by a non-measure beat");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_strongest <= IDX_W'(SENSOR_COUNT - 1)))
        else $error("strongest sensor index out of range");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DIV) |-> (r_cnt == '0))
        else $error("divide counter running outside divide");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE && m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result overwritten by merge");
`endif

endmodule
